FILE: hdl/point_in_oriented_box_set_top_assert.svh
// ----------------------------------------------------------------------------
// Oriented box set assertion macros
// Concurrent assertion shorthands for the point-in-box pipeline.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_ORIENTED_BOX_SET_TOP_ASSERT_SVH
`define POINT_IN_ORIENTED_BOX_SET_TOP_ASSERT_SVH

// same-cycle implication
`define PIBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pibs: implication failed");

// next-cycle implication
`define PIBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("pibs: next-cycle implication failed");

`endif

FILE: hdl/pibs_pkg.sv
// ----------------------------------------------------------------------------
// Oriented box set package
// Shared constants, codes and types for the point-in-box pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pibs_pkg;

	localparam int DEF_MAX_FRACTURES = 16;
	localparam int DEF_FRAC_BITS     = 16;
	localparam int MASK_BOXES        = 16;

	localparam int COORD_W     = 32;
	localparam int WORD_W      = 4;
	localparam int BOX_IDX_W   = 4;
	localparam int BOX_COUNT_W = 5;
	localparam int AXES_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int AXIS_WORDS  = 9;
	localparam int DIMS        = 3;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXES_IN_USE = 2'd1;

	localparam logic [AXES_W-1:0] AXES_PLANAR = 2'd2;
	localparam logic [AXES_W-1:0] AXES_VOLUME = 2'd3;

	localparam logic [WORD_W-1:0] WORD_CENTER = 4'd9;
	localparam logic [WORD_W-1:0] WORD_SIDE   = 4'd12;

	typedef struct packed {
		logic [WORD_W-1:0]         word;
		logic signed [COORD_W-1:0] value;
	} load_t;

endpackage

FILE: hdl/pibs_cell.sv
// ----------------------------------------------------------------------------
// Oriented box cell
// Holds one box and tests a point against it in a four-stage pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pibs_cell #(
	parameter int FRAC_BITS = pibs_pkg::DEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  pibs_pkg::load_t                      load,
	input  logic                                 planar,
	input  logic signed [pibs_pkg::COORD_W-1:0]  point_x,
	input  logic signed [pibs_pkg::COORD_W-1:0]  point_y,
	input  logic signed [pibs_pkg::COORD_W-1:0]  point_z,
	output logic                                 hit_s4
);
	import pibs_pkg::*;

	localparam int AXIS_W = FRAC_BITS + 2;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = AXIS_W + DIFF_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int CMP_W  = SUM_W + 2;

	logic signed [AXIS_W-1:0]  axis_q   [AXIS_WORDS];
	logic signed [COORD_W-1:0] center_q [DIMS];
	logic signed [COORD_W-1:0] side_q   [DIMS];

	logic signed [COORD_W-1:0] pt       [DIMS];
	logic signed [DIFF_W-1:0]  diff_s1  [DIMS];
	logic signed [PROD_W-1:0]  prod_c   [DIMS][DIMS];
	logic signed [PROD_W-1:0]  prod_s2  [DIMS][DIMS];
	logic signed [COORD_W-1:0] side_s2  [DIMS];
	logic signed [SUM_W-1:0]   sum_s3   [DIMS];
	logic signed [COORD_W-1:0] side_s3  [DIMS];
	logic signed [CMP_W-1:0]   twice_c  [DIMS];
	logic signed [CMP_W-1:0]   lim_c    [DIMS];
	logic [DIMS-1:0]           ok_c;

	// table words
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int k = 0; k < AXIS_WORDS; k++) begin
				if (load.word == WORD_W'(k))
					axis_q[k] <= load.value[AXIS_W-1:0];
			end
			for (int k = 0; k < DIMS; k++) begin
				if (load.word == WORD_CENTER + WORD_W'(k))
					center_q[k] <= load.value;
				if (load.word == WORD_SIDE + WORD_W'(k))
					side_q[k] <= load.value;
			end
		end
	end

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// s1: offset from centre
	always_ff @(posedge clk) begin
		for (int c = 0; c < DIMS; c++)
			diff_s1[c] <= DIFF_W'(pt[c]) - DIFF_W'(center_q[c]);
	end

	// s2: axis component products; z drops out in planar mode
	always_comb begin
		for (int a = 0; a < DIMS; a++) begin
			for (int c = 0; c < DIMS; c++) begin
				if (planar && c == DIMS - 1)
					prod_c[a][c] = '0;
				else
					prod_c[a][c] = PROD_W'(axis_q[a * DIMS + c]) * PROD_W'(diff_s1[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
		side_s2 <= side_q;
	end

	// s3: projections
	always_ff @(posedge clk) begin
		for (int a = 0; a < DIMS; a++)
			sum_s3[a] <= SUM_W'(prod_s2[a][0]) + SUM_W'(prod_s2[a][1]) + SUM_W'(prod_s2[a][2]);
		side_s3 <= side_s2;
	end

	// s4: -side < 2*proj < side, at projection scale
	always_comb begin
		for (int a = 0; a < DIMS; a++) begin
			twice_c[a] = {{(CMP_W - SUM_W - 1){sum_s3[a][SUM_W-1]}}, sum_s3[a], 1'b0};
			lim_c[a]   = {{(CMP_W - COORD_W - FRAC_BITS){side_s3[a][COORD_W-1]}},
				side_s3[a], {FRAC_BITS{1'b0}}};
			ok_c[a]    = !side_s3[a][COORD_W-1] && (side_s3[a] != '0)
				&& (twice_c[a] < lim_c[a]) && (twice_c[a] > -lim_c[a]);
		end
	end

	always_ff @(posedge clk) begin
		hit_s4 <= ok_c[0] && ok_c[1] && (ok_c[2] || planar);
	end

endmodule

FILE: hdl/point_in_oriented_box_set_top.sv
// Each query's done strobe passes through qv_s1, qv_s2, qv_s3, qv_s4 and done_s5; loads give no strobe.
// Throughput: one transaction per cycle; busy is low except during and just after reset.
// A load is seen by every query accepted after it.
// Reset clears configuration (box_count 0, axes_in_use 2) and the pipeline valids;
// box tables hold undefined data until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
// Oriented box set top level
// Table of oriented boxes tested in parallel against a stream of query points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_oriented_box_set_top #(
	parameter int MAX_FRACTURES = pibs_pkg::DEF_MAX_FRACTURES,
	parameter int FRAC_BITS     = pibs_pkg::DEF_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  action,
	input  logic [pibs_pkg::BOX_IDX_W-1:0]        box_index,
	input  logic [pibs_pkg::WORD_W-1:0]           word_select,
	input  logic signed [pibs_pkg::COORD_W-1:0]   load_value,
	input  logic signed [pibs_pkg::COORD_W-1:0]   point_x,
	input  logic signed [pibs_pkg::COORD_W-1:0]   point_y,
	input  logic signed [pibs_pkg::COORD_W-1:0]   point_z,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pibs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pibs_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  done,
	output logic [pibs_pkg::MASK_BOXES-1:0]       hit_mask,
	output logic                                  any_inside,
	output logic [pibs_pkg::BOX_COUNT_W-1:0]      hit_count
);
	import pibs_pkg::*;

	localparam int NCELL = (MAX_FRACTURES < MASK_BOXES) ? MAX_FRACTURES : MASK_BOXES;

	logic                   busy_q;
	logic [BOX_COUNT_W-1:0] box_count_q;
	logic [AXES_W-1:0]      axes_q;
	logic                   planar;
	logic                   item_fire;
	logic                   load_fire;
	logic                   query_fire;
	load_t                  load;
	logic [NCELL-1:0]       hit_vec;
	logic                   qv_s1, qv_s2, qv_s3, qv_s4;
	logic [MASK_BOXES-1:0]  mask_c;
	logic                   done_s5;
	logic [MASK_BOXES-1:0]  hit_mask_s5;
	logic [BOX_COUNT_W-1:0] hit_count_s5;

	function automatic logic [BOX_COUNT_W-1:0] count_ones(input logic [MASK_BOXES-1:0] v);
		logic [2:0]             nib [MASK_BOXES / 4];
		logic [BOX_COUNT_W-1:0] total;
		total = '0;
		for (int n = 0; n < MASK_BOXES / 4; n++)
			nib[n] = 3'(v[4 * n]) + 3'(v[4 * n + 1]) + 3'(v[4 * n + 2]) + 3'(v[4 * n + 3]);
		for (int n = 0; n < MASK_BOXES / 4; n++)
			total = total + BOX_COUNT_W'(nib[n]);
		return total;
	endfunction

	assign busy       = busy_q;
	assign cfg_ready  = 1'b1;
	assign item_fire  = start && !busy_q;
	assign load_fire  = item_fire && (action == ACT_LOAD);
	assign query_fire = item_fire && (action == ACT_QUERY);
	assign planar     = (axes_q != AXES_VOLUME);
	assign load.word  = word_select;
	assign load.value = load_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q <= '0;
			axes_q      <= AXES_PLANAR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BOX_COUNT:   box_count_q <= cfg_data;
				REG_AXES_IN_USE: axes_q      <= cfg_data[AXES_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		pibs_cell #(
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk     (clk),
			.wr_en   (load_fire && (box_index == BOX_IDX_W'(i))),
			.load    (load),
			.planar  (planar),
			.point_x (point_x),
			.point_y (point_y),
			.point_z (point_z),
			.hit_s4  (hit_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1   <= 1'b0;
			qv_s2   <= 1'b0;
			qv_s3   <= 1'b0;
			qv_s4   <= 1'b0;
			done_s5 <= 1'b0;
		end else begin
			qv_s1   <= query_fire;
			qv_s2   <= qv_s1;
			qv_s3   <= qv_s2;
			qv_s4   <= qv_s3;
			done_s5 <= qv_s4;
		end
	end

	// s5: gate inactive boxes, count hits
	always_comb begin
		mask_c = '0;
		for (int i = 0; i < NCELL; i++)
			mask_c[i] = hit_vec[i] && (box_count_q > BOX_COUNT_W'(i));
	end

	always_ff @(posedge clk) begin
		hit_mask_s5  <= mask_c;
		hit_count_s5 <= count_ones(mask_c);
	end

	assign done       = done_s5;
	assign hit_mask   = hit_mask_s5;
	assign any_inside = (hit_count_s5 != '0);
	assign hit_count  = hit_count_s5;

`include "point_in_oriented_box_set_top_assert.svh"

	`PIBS_ASSERT_NEXT(a_query_done, clk, arst_n, query_fire, ##4 done)
	`PIBS_ASSERT_IMPLY(a_done_from_query, clk, arst_n, done, $past(query_fire, 5))
	`PIBS_ASSERT_IMPLY(a_count_matches, clk, arst_n, done, int'(hit_count) == $countones(hit_mask))
	`PIBS_ASSERT_IMPLY(a_mask_active, clk, arst_n, done, (hit_mask >> box_count_q) == '0)

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Oriented box set testbench
// Drives load and query transactions into the box table, predicts each hit
// mask, hit flag and hit count from a local copy of the table and registers,
// and compares every done strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import pibs_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int PIPE_SETTLE    = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int AXIS_BITS      = DEF_FRAC_BITS + 2;
	localparam int NUM_BOXES      = DEF_MAX_FRACTURES;

	localparam logic [WORD_W-1:0]    WORD_AXIS   = 4'd0;
	localparam logic [WORD_W-1:0]    WORD_NONE   = 4'd15;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam logic [AXES_W-1:0]    AXES_ALT_0  = 2'd0;
	localparam logic [AXES_W-1:0]    AXES_ALT_1  = 2'd1;

	typedef struct {
		logic                      act;
		logic [BOX_IDX_W-1:0]      box;
		logic [WORD_W-1:0]         word;
		logic signed [COORD_W-1:0] value;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
	} box_txn_t;

	typedef struct {
		logic [MASK_BOXES-1:0]  hit_mask;
		logic                   any_inside;
		logic [BOX_COUNT_W-1:0] hit_count;
	} hit_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic action;
	logic [BOX_IDX_W-1:0] box_index;
	logic [WORD_W-1:0] word_select;
	logic signed [COORD_W-1:0] load_value;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic done;
	logic [MASK_BOXES-1:0] hit_mask;
	logic any_inside;
	logic [BOX_COUNT_W-1:0] hit_count;

	// local copy of the box table and registers
	logic signed [AXIS_BITS-1:0] axis_words [AXIS_WORDS*NUM_BOXES];
	logic signed [COORD_W-1:0]   center_words [DIMS*NUM_BOXES];
	logic signed [COORD_W-1:0]   side_words [DIMS*NUM_BOXES];
	logic [BOX_COUNT_W-1:0]      box_cfg;
	logic [AXES_W-1:0]           axes_cfg;

	hit_result_t expected_hits [$];
	int fail_count = 0;
	int idle_pct;
	int stall_cycles = 0;

	always #(CLK_PERIOD/2) clk = ~clk;

	point_in_oriented_box_set_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.box_index(box_index),
		.word_select(word_select),
		.load_value(load_value),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.hit_mask(hit_mask),
		.any_inside(any_inside),
		.hit_count(hit_count)
	);

	function automatic hit_result_t box_hits(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input logic signed [COORD_W-1:0] pz);
		hit_result_t res;
		longint pt [DIMS];
		longint diff [DIMS];
		longint proj;
		longint side;
		int n_axes;
		int n_boxes;
		int b;
		int a;
		int c;
		bit holds;
		n_axes = (axes_cfg == AXES_VOLUME) ? 3 : 2;
		n_boxes = (box_cfg > MASK_BOXES) ? MASK_BOXES : int'(box_cfg);
		pt[0] = longint'(px);
		pt[1] = longint'(py);
		pt[2] = (n_axes == 3) ? longint'(pz) : 0;
		res.hit_mask = '0;
		res.hit_count = '0;
		for (b = 0; b < n_boxes; b++) begin
			holds = 1'b1;
			for (c = 0; c < DIMS; c++)
				diff[c] = pt[c] - longint'(center_words[b*DIMS + c]);
			for (a = 0; a < n_axes; a++) begin
				proj = 0;
				for (c = 0; c < n_axes; c++)
					proj += longint'(axis_words[b*AXIS_WORDS + a*DIMS + c]) * diff[c];
				if (proj < 0)
					proj = -proj;
				side = longint'(side_words[b*DIMS + a]);
				if (side <= 0 || 2 * proj >= (side <<< DEF_FRAC_BITS))
					holds = 1'b0;
			end
			if (holds) begin
				res.hit_mask[b] = 1'b1;
				res.hit_count++;
			end
		end
		res.any_inside = (res.hit_mask != '0);
		return res;
	endfunction

	// one transaction; start stays high across back-to-back items
	task automatic send_txn(input box_txn_t t);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		action      <= t.act;
		box_index   <= t.box;
		word_select <= t.word;
		load_value  <= t.value;
		point_x     <= t.px;
		point_y     <= t.py;
		point_z     <= t.pz;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (t.act == ACT_QUERY) begin
			expected_hits.insert(expected_hits.size(), box_hits(t.px, t.py, t.pz));
		end else if (t.word < WORD_CENTER) begin
			axis_words[int'(t.box)*AXIS_WORDS + int'(t.word)] = t.value[AXIS_BITS-1:0];
		end else if (t.word < WORD_SIDE) begin
			center_words[int'(t.box)*DIMS + int'(t.word - WORD_CENTER)] = t.value;
		end else if (t.word != WORD_NONE) begin
			side_words[int'(t.box)*DIMS + int'(t.word - WORD_SIDE)] = t.value;
		end
	endtask

	task automatic load_word(input logic [BOX_IDX_W-1:0] b, input logic [WORD_W-1:0] w,
			input logic signed [COORD_W-1:0] v);
		box_txn_t t;
		t.act = ACT_LOAD;
		t.box = b;
		t.word = w;
		t.value = v;
		t.px = $urandom;
		t.py = $urandom;
		t.pz = $urandom;
		send_txn(t);
	endtask

	task automatic query_point(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z);
		box_txn_t t;
		t.act = ACT_QUERY;
		t.box = BOX_IDX_W'($urandom);
		t.word = WORD_W'($urandom);
		t.value = $urandom;
		t.px = x;
		t.py = y;
		t.pz = z;
		send_txn(t);
	endtask

	// point scattered around a box centre, roughly half inside
	task automatic query_near(input int tgt);
		logic signed [COORD_W-1:0] p [DIMS];
		longint reach;
		longint r;
		int c;
		reach = longint'(side_words[tgt*DIMS]);
		if (reach < 0)
			reach = -reach;
		if (reach < (1 << 16))
			reach = 1 << 16;
		if (reach > (32 << 16))
			reach = 32 << 16;
		r = reach / 2 + reach / 8;
		for (c = 0; c < DIMS; c++)
			p[c] = COORD_W'(longint'(center_words[tgt*DIMS + c])
				+ longint'($urandom_range(0, int'(2 * r))) - r);
		query_point(p[0], p[1], p[2]);
	endtask

	// rotated box about z, or pure noise words
	task automatic load_box(input logic [BOX_IDX_W-1:0] b, input bit well_formed);
		logic signed [COORD_W-1:0] w [15];
		longint cs;
		longint sn;
		longint tmp;
		int i;
		if (well_formed) begin
			case ($urandom_range(3))
				0: begin cs = 65536; sn = 0; end
				1: begin cs = 39322; sn = 52429; end
				2: begin cs = 25206; sn = 60495; end
				default: begin cs = 30840; sn = 57826; end
			endcase
			if ($urandom_range(1)) begin
				tmp = cs;
				cs = sn;
				sn = tmp;
			end
			if ($urandom_range(1))
				cs = -cs;
			if ($urandom_range(1))
				sn = -sn;
			w[0] = COORD_W'(cs);
			w[1] = COORD_W'(sn);
			w[2] = 0;
			w[3] = COORD_W'(-sn);
			w[4] = COORD_W'(cs);
			w[5] = 0;
			w[6] = 0;
			w[7] = 0;
			w[8] = $urandom_range(1) ? 65536 : -65536;
			for (i = 0; i < AXIS_WORDS; i++)
				if ($urandom_range(9) < 3)
					w[i][COORD_W-1:AXIS_BITS] = (COORD_W-AXIS_BITS)'($urandom);
			for (i = 0; i < DIMS; i++) begin
				w[WORD_CENTER + i] = COORD_W'(longint'($urandom_range(0, 2 << 20)) - (1 << 20));
				if ($urandom_range(99) < 92)
					w[WORD_SIDE + i] = $urandom_range(1 << 16, 24 << 16);
				else
					w[WORD_SIDE + i] = COORD_W'($urandom_range(1) ? 0 :
						-longint'($urandom_range(1, 1 << 20)));
			end
		end else begin
			for (i = 0; i < 15; i++)
				w[i] = $urandom;
		end
		for (i = 0; i < 15; i++) begin
			if ($urandom_range(9) == 0)
				load_word(BOX_IDX_W'($urandom), WORD_NONE, $urandom);
			load_word(b, WORD_W'(i), w[i]);
		end
	endtask

	task automatic drain_pipe();
		@(negedge clk);
		start <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_BOX_COUNT)
			box_cfg = data;
		else if (idx == REG_AXES_IN_USE)
			axes_cfg = data[AXES_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// no boxes active straight after reset
	task automatic test_empty_set();
		query_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		query_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
	endtask

	// box 0: unit axes with junk above the axis width, centre (10,-5,2), sides (4,2,6)
	task automatic test_table_load();
		load_word('0, WORD_AXIS + 4'd0, 32'hFFFD_0000);
		load_word('0, WORD_AXIS + 4'd1, 32'h8004_0000);
		load_word('0, WORD_AXIS + 4'd2, 32'h0000_0000);
		load_word('0, WORD_AXIS + 4'd3, 32'h0000_0000);
		load_word('0, WORD_AXIS + 4'd4, 32'hFFFF_0000);
		load_word('0, WORD_AXIS + 4'd5, 32'h7FFC_0000);
		load_word('0, WORD_AXIS + 4'd6, 32'h0000_0000);
		load_word('0, WORD_AXIS + 4'd7, 32'h0000_0000);
		load_word('0, WORD_AXIS + 4'd8, 32'h0001_0000);
		load_word('0, WORD_CENTER + 4'd0, 32'h000A_0000);
		load_word('0, WORD_CENTER + 4'd1, 32'hFFFB_0000);
		load_word('0, WORD_CENTER + 4'd2, 32'h0002_0000);
		load_word('0, WORD_NONE, 32'h7FFF_FFFF);
		load_word('0, WORD_SIDE + 4'd0, 32'h0004_0000);
		load_word('0, WORD_SIDE + 4'd1, 32'h0002_0000);
		load_word('0, WORD_SIDE + 4'd2, 32'h0006_0000);
	endtask

	// axes left at reset value: planar, z ignored, faces are outside
	task automatic test_planar_bounds();
		drain_pipe();
		set_reg(REG_BOX_COUNT, 5'd1);
		query_point(32'h000A_0000, 32'hFFFB_0000, 32'h7FFF_FFFF);
		query_point(32'h000C_0000, 32'hFFFB_0000, 32'h0000_0000);
		query_point(32'h000B_FFFF, 32'hFFFB_0000, 32'h0000_0000);
		query_point(32'h000A_0000, 32'hFFFC_0000, 32'h8000_0000);
		query_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
	endtask

	task automatic test_side_not_positive();
		load_word('0, WORD_SIDE + 4'd1, 32'h0000_0000);
		query_point(32'h000A_0000, 32'hFFFB_0000, 32'h0000_0000);
		load_word('0, WORD_SIDE + 4'd1, 32'h8000_0000);
		query_point(32'h000A_0000, 32'hFFFB_0000, 32'h0000_0000);
		load_word('0, WORD_SIDE + 4'd1, 32'h0002_0000);
	endtask

	task automatic test_volume_axis();
		drain_pipe();
		set_reg(REG_AXES_IN_USE, {3'b000, AXES_VOLUME});
		query_point(32'h000A_0000, 32'hFFFB_0000, 32'h0002_0000);
		query_point(32'h000A_0000, 32'hFFFB_0000, 32'h0005_0000);
	endtask

	// every box fully written before more than one is active
	task automatic test_fill_all_boxes();
		int b;
		for (b = 0; b < NUM_BOXES; b++) begin
			load_box(BOX_IDX_W'(b), (b % 4) != 3);
			repeat (2) query_near(0);
		end
	endtask

	task automatic test_random_phases();
		int counts [9];
		logic [AXES_W-1:0] modes [9];
		logic [CFG_DATA_W-1:0] axes_word;
		int p;
		int i;
		int r;
		int active;
		counts = '{16, 5, 31, 1, 16, 0, 17, 12, 16};
		modes = '{AXES_VOLUME, AXES_PLANAR, AXES_VOLUME, AXES_ALT_0, AXES_PLANAR,
			AXES_VOLUME, AXES_ALT_1, AXES_VOLUME, AXES_PLANAR};
		for (p = 0; p < 9; p++) begin
			idle_pct = (p < 3) ? 26 : (p < 6) ? 61 : 0;
			drain_pipe();
			set_reg(REG_BOX_COUNT, CFG_DATA_W'(counts[p]));
			axes_word = CFG_DATA_W'($urandom);
			axes_word[AXES_W-1:0] = modes[p];
			set_reg(REG_AXES_IN_USE, axes_word);
			if (p == 3) begin
				set_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
				set_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
			end
			active = (counts[p] > NUM_BOXES) ? NUM_BOXES : counts[p];
			for (i = 0; i < 85; i++) begin
				r = $urandom_range(99);
				if (r < 5)
					load_box(BOX_IDX_W'($urandom), $urandom_range(9) < 7);
				else if (r < 12)
					load_word(BOX_IDX_W'($urandom), WORD_W'($urandom), $urandom);
				else if (r < 85)
					query_near(active == 0 ? 0 : int'($urandom_range(active - 1)));
				else
					query_point($urandom, $urandom, $urandom);
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		hit_result_t exp_res;
		if (arst_n && done) begin
			if (expected_hits.size() == 0) begin
				$error("unexpected result: hit_mask %h any_inside %b hit_count %0d",
					hit_mask, any_inside, hit_count);
				fail_count++;
			end else begin
				exp_res = expected_hits.pop_front();
				if (hit_mask !== exp_res.hit_mask) begin
					$error("hit_mask: expected %h, got %h", exp_res.hit_mask, hit_mask);
					fail_count++;
				end
				if (any_inside !== exp_res.any_inside) begin
					$error("any_inside: expected %b, got %b", exp_res.any_inside, any_inside);
					fail_count++;
				end
				if (hit_count !== exp_res.hit_count) begin
					$error("hit_count: expected %0d, got %0d", exp_res.hit_count, hit_count);
					fail_count++;
				end
			end
		end
	end

	// cycles with no transaction of any kind
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		action      = ACT_LOAD;
		box_index   = '0;
		word_select = '0;
		load_value  = '0;
		point_x     = '0;
		point_y     = '0;
		point_z     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_BOX_COUNT;
		cfg_data    = '0;
		box_cfg     = '0;
		axes_cfg    = AXES_PLANAR;
		idle_pct    = 26;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_set();
		test_table_load();
		test_planar_bounds();
		test_side_not_positive();
		test_volume_axis();
		test_fill_all_boxes();
		test_random_phases();

		drain_pipe();
		if (fail_count == 0 && expected_hits.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
